// ===== src/i2c_mbe_pkg.sv =====
package i2c_mbe_pkg;

   // command opcodes carried on req_opcode
   localparam logic [2:0] OP_START     = 3'd0;
   localparam logic [2:0] OP_STOP      = 3'd1;
   localparam logic [2:0] OP_WRITE     = 3'd2;
   localparam logic [2:0] OP_READ      = 3'd3;
   localparam logic [2:0] OP_WAIT_ACK  = 3'd4;
   localparam logic [2:0] OP_SEND_ACK  = 3'd5;
   localparam logic [2:0] OP_SEND_NACK = 3'd6;

   // CSR map: register i at byte address 4*i
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_TICKS_PER_US = 1'b0;
   localparam logic CSR_ACK_TIMEOUT  = 1'b1;

   localparam int TICKS_W   = 10;
   localparam int TIMEOUT_W = 16;
   localparam int DELAY_W   = 13;

   localparam logic [TICKS_W-1:0]   TICKS_PER_US_RESET = 10'd16;
   localparam logic [TIMEOUT_W-1:0] ACK_TIMEOUT_RESET  = 16'd250;

endpackage

// ===== src/i2c_master_bit_engine.sv =====
// Channel   Ports                                   Direction  Moves
// req       req_valid/req_ready, req_* fields       in         one bus tick per transaction
// rsp       rsp_valid/rsp_ready, rsp_* fields       out        pin and status levels after the tick
// csr       csr_psel/penable/pwrite/paddr/pwdata    in         ticks_per_us (0x0), ack timeout (0x4)
//
// One tick is taken per cycle while req_ready is high; its result appears in the rsp register the next cycle.
// The tick logic is a single pass from the state registers to the result register.
// req_ready stays high while the rsp register is empty or being taken this cycle.
// A stalled rsp holds the engine: no tick advances until the result is taken.
// Synchronous active-high reset: bus idle with SCL and SDA high, SDA driven.
module i2c_master_bit_engine (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_cmd_valid,
   input  logic [2:0]                          req_opcode,
   input  logic [7:0]                          req_write_data,
   input  logic                                req_sda_in,

   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_scl_out,
   output logic                                rsp_sda_out,
   output logic                                rsp_sda_drive,
   output logic                                rsp_busy_res,
   output logic                                rsp_done_res,
   output logic [7:0]                          rsp_read_data,
   output logic                                rsp_no_ack,

   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [i2c_mbe_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [i2c_mbe_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [i2c_mbe_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                                csr_pready
);

   typedef enum logic [3:0] {
      PH_IDLE, PH_ST_A, PH_ST_B, PH_ST_C, PH_SP_A, PH_SP_B,
      PH_WR_SET, PH_WR_HIGH, PH_WR_LOW, PH_RD_HIGH, PH_RD_LOW,
      PH_WA_POLL, PH_WA_END, PH_AK_LOW, PH_AK_HIGH
   } phase_type;

   localparam int TW = i2c_mbe_pkg::TICKS_W;
   localparam int OW = i2c_mbe_pkg::TIMEOUT_W;
   localparam int DW = i2c_mbe_pkg::DELAY_W;

   // configuration
   logic [TW-1:0] ticks_per_us_ff;
   logic [OW-1:0] ack_timeout_ff;
   logic          csr_write;

   // engine state
   phase_type     phase_ff, phase_in;
   logic [2:0]    bit_index_ff, bit_index_in;
   logic [7:0]    shift_ff, shift_in;
   logic [DW-1:0] delay_ff, delay_in;
   logic [OW-1:0] ack_cnt_ff, ack_cnt_in;
   logic          scl_ff, scl_in;
   logic          sda_ff, sda_in;
   logic          sda_en_ff, sda_en_in;
   logic [7:0]    last_read_ff, last_read_in;
   logic          ack_missing_ff, ack_missing_in;
   logic          done;

   // result register
   logic          rsp_valid_ff;
   logic          rsp_done_ff;
   logic          req_accept;

   // hold lengths
   logic [TW-1:0] tick_us;
   logic [DW-1:0] hold2, hold4, hold5;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_per_us_ff <= i2c_mbe_pkg::TICKS_PER_US_RESET;
         ack_timeout_ff  <= i2c_mbe_pkg::ACK_TIMEOUT_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            i2c_mbe_pkg::CSR_TICKS_PER_US: ticks_per_us_ff <= csr_pwdata[TW-1:0];
            i2c_mbe_pkg::CSR_ACK_TIMEOUT:  ack_timeout_ff  <= csr_pwdata[OW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         i2c_mbe_pkg::CSR_TICKS_PER_US:
            csr_prdata = {{(i2c_mbe_pkg::CSR_DATA_W-TW){1'b0}}, ticks_per_us_ff};
         i2c_mbe_pkg::CSR_ACK_TIMEOUT:
            csr_prdata = {{(i2c_mbe_pkg::CSR_DATA_W-OW){1'b0}}, ack_timeout_ff};
         default:
            csr_prdata = '0;
      endcase
   end

   // zero ticks_per_us behaves as one
   assign tick_us = (ticks_per_us_ff == '0) ? TW'(1) : ticks_per_us_ff;
   assign hold2   = {{(DW-TW-1){1'b0}}, tick_us, 1'b0};
   assign hold4   = {{(DW-TW-2){1'b0}}, tick_us, 2'b00};
   assign hold5   = hold4 + {{(DW-TW){1'b0}}, tick_us};

   assign req_ready  = ~rsp_valid_ff | rsp_ready;
   assign req_accept = req_valid & req_ready;

   always_comb begin
      phase_in       = phase_ff;
      bit_index_in   = bit_index_ff;
      shift_in       = shift_ff;
      delay_in       = delay_ff;
      ack_cnt_in     = ack_cnt_ff;
      scl_in         = scl_ff;
      sda_in         = sda_ff;
      sda_en_in      = sda_en_ff;
      last_read_in   = last_read_ff;
      ack_missing_in = ack_missing_ff;
      done           = 1'b0;

      unique case (phase_ff)
         PH_IDLE: begin
            if (req_cmd_valid) begin
               unique case (req_opcode) inside
                  i2c_mbe_pkg::OP_START: begin
                     sda_en_in = 1'b1;
                     sda_in    = 1'b1;
                     scl_in    = 1'b1;
                     delay_in  = hold4;
                     phase_in  = PH_ST_A;
                  end
                  i2c_mbe_pkg::OP_STOP: begin
                     sda_en_in = 1'b1;
                     sda_in    = 1'b0;
                     scl_in    = 1'b1;
                     delay_in  = hold4;
                     phase_in  = PH_SP_A;
                  end
                  i2c_mbe_pkg::OP_WRITE: begin
                     sda_en_in    = 1'b1;
                     scl_in       = 1'b0;
                     bit_index_in = '0;
                     sda_in       = req_write_data[7];
                     shift_in     = {req_write_data[6:0], 1'b0};
                     delay_in     = hold5;
                     phase_in     = PH_WR_SET;
                  end
                  i2c_mbe_pkg::OP_READ: begin
                     sda_en_in    = 1'b0;
                     sda_in       = 1'b1;
                     shift_in     = '0;
                     bit_index_in = '0;
                     scl_in       = 1'b1;
                     delay_in     = hold5;
                     phase_in     = PH_RD_HIGH;
                  end
                  i2c_mbe_pkg::OP_WAIT_ACK: begin
                     sda_en_in      = 1'b0;
                     sda_in         = 1'b1;
                     scl_in         = 1'b1;
                     ack_cnt_in     = '0;
                     ack_missing_in = 1'b0;
                     phase_in       = PH_WA_POLL;
                  end
                  i2c_mbe_pkg::OP_SEND_ACK, i2c_mbe_pkg::OP_SEND_NACK: begin
                     scl_in    = 1'b0;
                     sda_en_in = 1'b1;
                     sda_in    = (req_opcode == i2c_mbe_pkg::OP_SEND_NACK);
                     delay_in  = hold2;
                     phase_in  = PH_AK_LOW;
                  end
                  default: ;
               endcase
            end
         end
         PH_WA_POLL: begin
            if (!req_sda_in) begin
               scl_in   = 1'b0;
               delay_in = hold4;
               phase_in = PH_WA_END;
            end else if (ack_cnt_ff >= ack_timeout_ff) begin
               // timeout: flag it and run a stop
               ack_missing_in = 1'b1;
               sda_en_in      = 1'b1;
               sda_in         = 1'b0;
               scl_in         = 1'b1;
               delay_in       = hold4;
               phase_in       = PH_SP_A;
            end else begin
               ack_cnt_in = ack_cnt_ff + OW'(1);
            end
         end
         default: begin
            if (delay_ff > DW'(1)) begin
               delay_in = delay_ff - DW'(1);
            end else begin
               // hold expired: next pin action
               unique case (phase_ff)
                  PH_ST_A: begin
                     sda_in = 1'b0; delay_in = hold4; phase_in = PH_ST_B;
                  end
                  PH_ST_B: begin
                     scl_in = 1'b0; delay_in = hold4; phase_in = PH_ST_C;
                  end
                  PH_SP_A: begin
                     sda_in = 1'b1; delay_in = hold4; phase_in = PH_SP_B;
                  end
                  PH_WR_SET: begin
                     scl_in = 1'b1; delay_in = hold5; phase_in = PH_WR_HIGH;
                  end
                  PH_WR_HIGH: begin
                     scl_in = 1'b0; delay_in = hold2; phase_in = PH_WR_LOW;
                  end
                  PH_WR_LOW: begin
                     if (bit_index_ff < 3'd7) begin
                        bit_index_in = bit_index_ff + 3'd1;
                        sda_in       = shift_ff[7];
                        shift_in     = {shift_ff[6:0], 1'b0};
                        delay_in     = hold5;
                        phase_in     = PH_WR_SET;
                     end else begin
                        done = 1'b1;
                     end
                  end
                  PH_RD_HIGH: begin
                     shift_in = {shift_ff[7:1], shift_ff[0] | req_sda_in};
                     scl_in   = 1'b0;
                     delay_in = hold5;
                     phase_in = PH_RD_LOW;
                  end
                  PH_RD_LOW: begin
                     if (bit_index_ff < 3'd7) begin
                        bit_index_in = bit_index_ff + 3'd1;
                        shift_in     = {shift_ff[6:0], 1'b0};
                        scl_in       = 1'b1;
                        delay_in     = hold5;
                        phase_in     = PH_RD_HIGH;
                     end else begin
                        last_read_in = shift_ff;
                        done         = 1'b1;
                     end
                  end
                  PH_AK_LOW: begin
                     scl_in = 1'b1; delay_in = hold2; phase_in = PH_AK_HIGH;
                  end
                  PH_AK_HIGH: begin
                     scl_in = 1'b0; done = 1'b1;
                  end
                  default: done = 1'b1;
               endcase
               if (done) begin
                  phase_in = PH_IDLE;
                  delay_in = '0;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         bit_index_ff   <= '0;
         shift_ff       <= '0;
         delay_ff       <= '0;
         ack_cnt_ff     <= '0;
         scl_ff         <= 1'b1;
         sda_ff         <= 1'b1;
         sda_en_ff      <= 1'b1;
         last_read_ff   <= '0;
         ack_missing_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         rsp_done_ff    <= 1'b0;
      end else begin
         if (req_accept) begin
            phase_ff       <= phase_in;
            bit_index_ff   <= bit_index_in;
            shift_ff       <= shift_in;
            delay_ff       <= delay_in;
            ack_cnt_ff     <= ack_cnt_in;
            scl_ff         <= scl_in;
            sda_ff         <= sda_in;
            sda_en_ff      <= sda_en_in;
            last_read_ff   <= last_read_in;
            ack_missing_ff <= ack_missing_in;
            rsp_done_ff    <= done;
            rsp_valid_ff   <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff   <= 1'b0;
         end
      end
   end

   // the state registers double as the result fields
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_scl_out   = scl_ff;
   assign rsp_sda_out   = sda_ff;
   assign rsp_sda_drive = sda_en_ff;
   assign rsp_busy_res  = (phase_ff != PH_IDLE);
   assign rsp_done_res  = rsp_done_ff;
   assign rsp_read_data = last_read_ff;
   assign rsp_no_ack    = ack_missing_ff;

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("tick accepted over a stalled result");

   a_idle_no_delay: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> (delay_ff == '0))
      else $error("hold count left over in idle");

   a_idle_no_done: assert property (@(posedge clock) disable iff (reset)
      (req_accept && phase_ff == PH_IDLE) |=> !rsp_done_res)
      else $error("done raised on a tick taken in idle");

   a_wait_ack_release: assert property (@(posedge clock) disable iff (reset)
      (req_accept && phase_ff == PH_IDLE && req_cmd_valid
       && req_opcode == i2c_mbe_pkg::OP_WAIT_ACK)
      |=> (!rsp_sda_drive && rsp_busy_res && !rsp_no_ack && rsp_scl_out))
      else $error("wait-ack did not release SDA with SCL high");

endmodule
